FILE: rtl/tcw_pkg.sv
// ----------------------------------------------------------------------------
// tcw_pkg
// Shared types, request codes and a helper function for the text console writer.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLS_DEF = 80;
    localparam int ROWS_DEF = 25;

    typedef enum logic [1:0] {
        REQ_CHAR   = 2'd0,
        REQ_SCROLL = 2'd1,
        REQ_CLEAR  = 2'd2,
        REQ_READ   = 2'd3
    } req_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_POS_ERR = 2'd1;
    localparam logic [1:0] ST_IGNORED = 2'd2;

    localparam logic [7:0] CH_NL    = 8'd10;
    localparam logic [7:0] CH_CR    = 8'd13;
    localparam logic [7:0] CH_TAB   = 8'd9;
    localparam logic [7:0] CH_BLANK = 8'h20;
    localparam logic [7:0] FILL_ATTR_RST = 8'h07;
    localparam logic [15:0] CELL_RST = 16'h0720;

    localparam logic [0:0] ADDR_FILL_ATTR = 1'b0;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [7:0]  char_code;
        logic [7:0]  char_attr;
        logic [6:0]  start_col;
        logic [4:0]  start_row;
        logic        first_char;
        logic        last_char;
        logic [4:0]  line_count;
        logic [10:0] cell_index;
        logic [7:0]  red;
        logic [7:0]  green;
        logic [7:0]  blue;
    } in_item_t;

    typedef struct packed {
        logic [1:0]  status;
        logic [15:0] cell_data;
        logic [6:0]  cursor_col;
        logic [4:0]  cursor_row;
        logic [11:0] cursor_pos;
        logic        did_scroll;
    } out_item_t;

    // Map a clear color to its attribute byte.
    function automatic logic [7:0] colour_attr(logic [7:0] r, logic [7:0] g, logic [7:0] b);
        logic [7:0] a;
        if (r > g && r > b)      a = (r > 8'd128) ? 8'h0C : 8'h04;
        else if (g > r && g > b) a = (g > 8'd128) ? 8'h0A : 8'h02;
        else if (b > r && b > g) a = (b > 8'd128) ? 8'h09 : 8'h01;
        else if (r == g && g == b)
        begin
            if (r < 8'd64)       a = 8'h00;
            else if (r < 8'd128) a = 8'h08;
            else if (r < 8'd192) a = 8'h07;
            else                 a = 8'h0F;
        end
        else                     a = 8'h07;
        return a;
    endfunction

endpackage

FILE: rtl/text_console_writer.sv
// ----------------------------------------------------------------------------
// text_console_writer
// 80x25 text console: character put, scroll, clear and cell read.
// ----------------------------------------------------------------------------
// A scroll copies each kept cell with a read and a write, then fills the freed
// cells with blanks; a full blank or a clear fills every cell; a character that
// scrolls is written after the scroll; other requests need no sweep.
// The engine carries out one request at a time; the next is taken after its result is accepted.
// Reset: async; an init pass writes 0x0720 to every cell; fill_attr resets to 0x07.
module text_console_writer
    import tcw_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  in_item_t    in_item,
    output logic        out_valid,
    input  logic        out_stall,
    output out_item_t   out_item,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [0:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    logic [7:0] fill_attr_reg;
    logic       q_valid, q_pop;
    in_item_t   q_item;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_FILL_ATTR) ? {24'd0, fill_attr_reg} : 32'd0;

    // Hold fill_attr; take APB writes on the access phase.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            fill_attr_reg <= FILL_ATTR_RST;
        else if (psel && penable && pwrite && paddr == ADDR_FILL_ATTR)
            fill_attr_reg <= pwdata[7:0];
    end

    tcw_front u_front (
        .clk, .rst_n, .in_valid, .in_stall, .in_item,
        .q_valid, .q_item, .q_pop
    );

    tcw_engine #(.COLS(COLS), .ROWS(ROWS)) u_engine (
        .clk, .rst_n, .fill_attr(fill_attr_reg),
        .q_valid, .q_item, .q_pop,
        .out_valid, .out_stall, .out_item
    );
endmodule

FILE: rtl/tcw_front.sv
// ----------------------------------------------------------------------------
// tcw_front
// Input stage: accept transactions into a short queue ahead of the engine.
// ----------------------------------------------------------------------------
module tcw_front
    import tcw_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  logic     in_valid,
    output logic     in_stall,
    input  in_item_t in_item,
    output logic     q_valid,
    output in_item_t q_item,
    input  logic     q_pop
);
    // two-entry queue
    in_item_t  mem_reg [2];
    logic      wp_reg, wp_next, rp_reg, rp_next;
    logic [1:0] cnt_reg, cnt_next;
    logic      push;

    assign in_stall = (cnt_reg == 2'd2);
    assign push     = in_valid && !in_stall;
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = mem_reg[rp_reg];

    always_comb
    begin
        wp_next  = push ? ~wp_reg : wp_reg;
        rp_next  = q_pop ? ~rp_reg : rp_reg;
        cnt_next = cnt_reg + {1'b0, push} - {1'b0, q_pop};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wp_reg  <= 1'b0;
            rp_reg  <= 1'b0;
            cnt_reg <= 2'd0;
        end
        else
        begin
            wp_reg  <= wp_next;
            rp_reg  <= rp_next;
            cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem_reg[wp_reg] <= in_item;
    end

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> q_valid)
        else $error("pop from empty queue");
    assert property (@(posedge clk) disable iff (!rst_n) cnt_reg != 2'd3)
        else $error("queue count overflow");
    assert property (@(posedge clk) disable iff (!rst_n)
        (cnt_reg == 2'd2 && !q_pop) |=> cnt_reg == 2'd2)
        else $error("full queue lost an entry");
endmodule

FILE: rtl/tcw_engine.sv
// ----------------------------------------------------------------------------
// tcw_engine
// Back end: carry out one request against the screen memory.
// ----------------------------------------------------------------------------
module tcw_engine
    import tcw_pkg::*;
#(
    parameter int COLS = COLS_DEF,
    parameter int ROWS = ROWS_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic [7:0] fill_attr,
    input  logic       q_valid,
    input  in_item_t   q_item,
    output logic       q_pop,
    output logic       out_valid,
    input  logic       out_stall,
    output out_item_t  out_item
);
    localparam int CELLS = COLS * ROWS;
    localparam int AW = $clog2(CELLS);

    typedef enum logic [6:0] {
        S_INIT = 7'b0000001,
        S_IDLE = 7'b0000010,
        S_SRD  = 7'b0000100,
        S_SWR  = 7'b0001000,
        S_CWR  = 7'b0010000,
        S_READ = 7'b0100000,
        S_OUT  = 7'b1000000
    } state_t;

    state_t state_reg, state_next;

    logic [15:0]   mem [CELLS];
    logic [15:0]   rd_reg;
    logic          we;
    logic [AW-1:0] waddr, raddr;
    logic [15:0]   wdata;

    logic [6:0]    wcol_reg, wcol_next, ccol_reg, ccol_next;
    logic [4:0]    wrow_reg, wrow_next, crow_reg, crow_next;
    logic          abort_reg, abort_next;
    logic [AW-1:0] ptr_reg, ptr_next;       // sweep pointer
    logic [AW-1:0] lim_reg, lim_next;       // cells copied before the fill starts
    logic [AW-1:0] off_reg, off_next;       // copy distance in cells
    logic [15:0]   fv_reg, fv_next;         // fill value
    logic [1:0]    st_reg, st_next;
    logic          scr_reg, scr_next;
    logic [15:0]   cell_reg, cell_next;
    logic          resume_reg, resume_next; // finish a character after its scroll
    logic          cwe_reg, cwe_next;       // character cell write pending
    logic [AW-1:0] caddr_reg, caddr_next;
    logic [15:0]   cdata_reg, cdata_next;

    // combinational temporaries for the character path
    logic [7:0] c;
    logic [5:0] r;
    logic       adv, prt, err;

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rd_reg <= mem[raddr];
    end

    always_comb
    begin
        state_next  = state_reg;
        wcol_next   = wcol_reg;
        wrow_next   = wrow_reg;
        ccol_next   = ccol_reg;
        crow_next   = crow_reg;
        abort_next  = abort_reg;
        ptr_next    = ptr_reg;
        lim_next    = lim_reg;
        off_next    = off_reg;
        fv_next     = fv_reg;
        st_next     = st_reg;
        scr_next    = scr_reg;
        cell_next   = cell_reg;
        resume_next = resume_reg;
        cwe_next    = cwe_reg;
        caddr_next  = caddr_reg;
        cdata_next  = cdata_reg;
        we    = 1'b0;
        waddr = ptr_reg;
        wdata = fv_reg;
        raddr = ptr_reg;
        q_pop = 1'b0;
        c   = {1'b0, wcol_reg};
        r   = {1'b0, wrow_reg};
        adv = 1'b0;
        prt = 1'b0;
        err = 1'b0;
        unique case (state_reg)
            S_INIT:
            begin
                we    = 1'b1;
                wdata = CELL_RST;
                if (ptr_reg == AW'(CELLS - 1))
                begin
                    ptr_next   = '0;
                    state_next = S_IDLE;
                end
                else
                    ptr_next = ptr_reg + AW'(1);
            end
            S_IDLE:
            begin
                if (q_valid)
                begin
                    q_pop       = 1'b1;
                    st_next     = ST_OK;
                    scr_next    = 1'b0;
                    cell_next   = 16'd0;
                    resume_next = 1'b0;
                    cwe_next    = 1'b0;
                    state_next  = S_OUT;
                    unique case (q_item.req_type)
                        REQ_CHAR:
                        begin
                            if (q_item.first_char)
                            begin
                                c = {1'b0, q_item.start_col};
                                r = {1'b0, q_item.start_row};
                                abort_next = 1'b0;
                            end
                            if (abort_reg && !q_item.first_char)
                                st_next = ST_IGNORED;
                            else
                            begin
                                case (q_item.char_code)
                                    CH_NL: adv = 1'b1;
                                    CH_CR: c = 8'd0;
                                    CH_TAB:
                                    begin
                                        c   = (c + 8'd4) & 8'hFC;
                                        adv = (c >= 8'(COLS));
                                    end
                                    default:
                                    begin
                                        adv = (c >= 8'(COLS));
                                        prt = 1'b1;
                                    end
                                endcase
                                // next row; past the bottom the screen moves up one line
                                if (adv)
                                begin
                                    c = 8'd0;
                                    r = r + 6'd1;
                                    if (r >= 6'(ROWS))
                                    begin
                                        r           = 6'(ROWS - 1);
                                        scr_next    = 1'b1;
                                        resume_next = 1'b1;
                                        fv_next     = {fill_attr, CH_BLANK};
                                        off_next    = AW'(COLS);
                                        lim_next    = AW'((ROWS - 1) * COLS);
                                        ptr_next    = '0;
                                    end
                                end
                                if (prt && r >= 6'(ROWS))
                                begin
                                    // start row below the screen: abort the string
                                    err        = 1'b1;
                                    st_next    = ST_POS_ERR;
                                    abort_next = 1'b1;
                                end
                                else if (prt)
                                begin
                                    cwe_next   = 1'b1;
                                    caddr_next = AW'(int'(r) * COLS + int'(c));
                                    cdata_next = {q_item.char_attr, q_item.char_code};
                                    c = c + 8'd1;
                                end
                                wcol_next = c[6:0];
                                wrow_next = r[4:0];
                                if (!err && q_item.last_char)
                                begin
                                    ccol_next = c[6:0];
                                    crow_next = r[4:0];
                                end
                                if (resume_next)
                                    state_next = S_SRD;
                                else if (cwe_next)
                                    state_next = S_CWR;
                            end
                        end
                        REQ_SCROLL:
                        begin
                            if (q_item.line_count != 5'd0)
                            begin
                                scr_next = 1'b1;
                                fv_next  = {fill_attr, CH_BLANK};
                                ptr_next = '0;
                                if (int'(q_item.line_count) >= ROWS)
                                begin
                                    off_next = '0;
                                    lim_next = '0;
                                end
                                else
                                begin
                                    off_next = AW'(int'(q_item.line_count) * COLS);
                                    lim_next = AW'((ROWS - int'(q_item.line_count)) * COLS);
                                end
                                state_next = S_SRD;
                            end
                        end
                        REQ_CLEAR:
                        begin
                            fv_next = {colour_attr(q_item.red, q_item.green, q_item.blue),
                                       CH_BLANK};
                            off_next  = '0;
                            lim_next  = '0;
                            ptr_next  = '0;
                            ccol_next = '0;
                            crow_next = '0;
                            wcol_next = '0;
                            wrow_next = '0;
                            state_next = S_SRD;
                        end
                        REQ_READ:
                        begin
                            if (int'(q_item.cell_index) < CELLS)
                            begin
                                raddr      = AW'(q_item.cell_index);
                                state_next = S_READ;
                            end
                        end
                    endcase
                end
            end
            S_SRD:
            begin
                // copy phase reads ptr+off, fill phase writes directly
                if (ptr_reg < lim_reg)
                begin
                    raddr      = ptr_reg + off_reg;
                    state_next = S_SWR;
                end
                else
                begin
                    we = 1'b1;
                    if (ptr_reg == AW'(CELLS - 1))
                        state_next = resume_reg ? S_CWR : S_OUT;
                    else
                        ptr_next = ptr_reg + AW'(1);
                end
            end
            S_SWR:
            begin
                we         = 1'b1;
                wdata      = rd_reg;
                ptr_next   = ptr_reg + AW'(1);
                state_next = S_SRD;
            end
            S_CWR:
            begin
                if (cwe_reg)
                begin
                    we    = 1'b1;
                    waddr = caddr_reg;
                    wdata = cdata_reg;
                end
                state_next = S_OUT;
            end
            S_READ:
            begin
                cell_next  = rd_reg;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!out_stall)
                    state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_INIT;
            wcol_reg   <= '0;
            wrow_reg   <= '0;
            ccol_reg   <= '0;
            crow_reg   <= '0;
            abort_reg  <= 1'b0;
            ptr_reg    <= '0;
            lim_reg    <= '0;
            off_reg    <= '0;
            fv_reg     <= '0;
            st_reg     <= ST_OK;
            scr_reg    <= 1'b0;
            cell_reg   <= '0;
            resume_reg <= 1'b0;
            cwe_reg    <= 1'b0;
            caddr_reg  <= '0;
            cdata_reg  <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            wcol_reg   <= wcol_next;
            wrow_reg   <= wrow_next;
            ccol_reg   <= ccol_next;
            crow_reg   <= crow_next;
            abort_reg  <= abort_next;
            ptr_reg    <= ptr_next;
            lim_reg    <= lim_next;
            off_reg    <= off_next;
            fv_reg     <= fv_next;
            st_reg     <= st_next;
            scr_reg    <= scr_next;
            cell_reg   <= cell_next;
            resume_reg <= resume_next;
            cwe_reg    <= cwe_next;
            caddr_reg  <= caddr_next;
            cdata_reg  <= cdata_next;
        end
    end

    assign out_valid = (state_reg == S_OUT);
    always_comb
    begin
        out_item.status     = st_reg;
        out_item.cell_data  = cell_reg;
        out_item.cursor_col = ccol_reg;
        out_item.cursor_row = crow_reg;
        out_item.cursor_pos = 12'(int'(crow_reg) * COLS + int'(ccol_reg));
        out_item.did_scroll = scr_reg;
    end

    assert property (@(posedge clk) disable iff (!rst_n) q_pop |-> state_reg == S_IDLE)
        else $error("dispatch outside idle");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(out_item)))
        else $error("result dropped or changed while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.status == ST_POS_ERR) |-> abort_reg)
        else $error("position error without abort");
    assert property (@(posedge clk) disable iff (!rst_n) $onehot(state_reg))
        else $error("state not one-hot");
endmodule
